// File: sv/lgs_pkg.sv
// Shared widths, register codes and operand types for the LDA token sampler.
`default_nettype none
package lgs_pkg;

  localparam int MAX_TOPICS  = 64;
  localparam int TOPIC_W     = 6;
  localparam int K_W         = 7;
  localparam int DOC_W       = 10;
  localparam int WORD_W      = 12;
  localparam int FRAC_W      = 32;
  localparam int DCNT_W      = 16;
  localparam int WCNT_W      = 20;
  localparam int TOT_W       = 24;
  localparam int DOC_ADDR_W  = DOC_W + TOPIC_W;
  localparam int WORD_ADDR_W = WORD_W + TOPIC_W;

  localparam int A_W = 33;   // alpha + nd<<16
  localparam int B_W = 37;   // beta + nw<<16
  localparam int C_W = 41;   // beta_bar + nt<<16
  localparam int P_W = A_W + B_W;
  localparam int W_W = 48;
  localparam int STEP_W = 7;

  localparam logic [W_W-1:0] WEIGHT_MAX = {W_W{1'b1}};

  // register codes, paddr[3:2]
  localparam logic [1:0] REG_NUM_TOPICS = 2'd0;
  localparam logic [1:0] REG_ALPHA      = 2'd1;
  localparam logic [1:0] REG_BETA       = 2'd2;
  localparam logic [1:0] REG_BETA_BAR   = 2'd3;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic [B_W-1:0] b;
    logic [C_W-1:0] c;
  } lgs_wu_ops_t;

endpackage
`default_nettype wire

// File: sv/lda_collapsed_gibbs_token_sampler.sv
// Top level of the LDA collapsed Gibbs token sampler.
// After reset the block sweeps its count memories to zero, one word-table entry per cycle,
// with in_tready low (configuration writes are taken throughout). An init transfer
// (tuser 0) is one read-modify-write of the three counts. In a resample transfer
// (tuser 1), with k topics in use, each topic weight goes through one shared iterative
// unit (shift-add multiply, then restoring divide), the scaled target comes from a
// shift-add multiply, and the search reads the running sums in topic order from the
// running-sum memory up to the picked topic. One item is worked on at a time; a finished
// result waits in the output register while the next transfer is accepted.
`default_nettype none
module lda_collapsed_gibbs_token_sampler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // doc_index[9:0], word_index[21:10],
                                      // current_topic[27:22], random_fraction[59:28]
  input  wire logic        in_tuser,  // op: 0 init, 1 resample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // sampled_topic[5:0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int TW  = lgs_pkg::TOPIC_W;
  localparam int KW  = lgs_pkg::K_W;
  localparam int CLR_W = lgs_pkg::WORD_ADDR_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RD1   = 4'd2;
  localparam logic [3:0] ST_WB1   = 4'd3;
  localparam logic [3:0] ST_WRD   = 4'd4;
  localparam logic [3:0] ST_WDAT  = 4'd5;
  localparam logic [3:0] ST_WWAIT = 4'd6;
  localparam logic [3:0] ST_TGT   = 4'd7;
  localparam logic [3:0] ST_SRD   = 4'd8;
  localparam logic [3:0] ST_SCMP  = 4'd9;
  localparam logic [3:0] ST_RD2   = 4'd10;
  localparam logic [3:0] ST_WB2   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  localparam logic [lgs_pkg::DCNT_W-1:0] DCNT_MAX = {lgs_pkg::DCNT_W{1'b1}};
  localparam logic [lgs_pkg::WCNT_W-1:0] WCNT_MAX = {lgs_pkg::WCNT_W{1'b1}};
  localparam logic [lgs_pkg::TOT_W-1:0]  TOT_MAX  = {lgs_pkg::TOT_W{1'b1}};
  localparam logic [KW-1:0] K_LIMIT = KW'(lgs_pkg::MAX_TOPICS);

  // configuration
  logic [KW-1:0] num_topics_r;
  logic [31:0]   alpha_r, beta_r, beta_bar_r;
  logic [KW-1:0] k_w;
  logic          cfg_wr;

  // control
  logic [3:0]       state_r, state_nxt;
  logic [CLR_W-1:0] clr_r;
  logic [TW-1:0]    t_r, t_nxt;
  logic [TW-1:0]    pick_r, pick_nxt;
  logic [4:0]       tcnt_r, tcnt_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [TW-1:0]    out_topic_r, out_topic_nxt;

  // item and datapath
  logic                        op_r;
  logic [lgs_pkg::DOC_W-1:0]   doc_r;
  logic [lgs_pkg::WORD_W-1:0]  word_r;
  logic [TW-1:0]               cur_r;
  logic [lgs_pkg::FRAC_W-1:0]  frac_r, frac_nxt;
  logic [lgs_pkg::W_W-1:0]     sum_r, sum_nxt;
  logic [79:0]                 acc_r, acc_nxt;
  logic [lgs_pkg::W_W:0]       sum_add;
  logic [lgs_pkg::W_W:0]       acc_add;
  logic [lgs_pkg::W_W-1:0]     sum_sat;
  logic [lgs_pkg::W_W-1:0]     target;
  logic                        last_t;

  // memories
  logic [lgs_pkg::DCNT_W-1:0] doc_mem  [0:(1 << lgs_pkg::DOC_ADDR_W)-1];
  logic [lgs_pkg::WCNT_W-1:0] word_mem [0:(1 << lgs_pkg::WORD_ADDR_W)-1];
  logic [lgs_pkg::TOT_W-1:0]  tot_mem  [0:lgs_pkg::MAX_TOPICS-1];
  logic [lgs_pkg::W_W-1:0]    rw_mem   [0:lgs_pkg::MAX_TOPICS-1];
  logic [lgs_pkg::DCNT_W-1:0] doc_rd_r;
  logic [lgs_pkg::WCNT_W-1:0] word_rd_r;
  logic [lgs_pkg::TOT_W-1:0]  tot_rd_r;
  logic [lgs_pkg::W_W-1:0]    rw_rd_r;

  logic [TW-1:0]    rd_topic, wr_topic;
  logic             up, upd_en, clearing;
  logic             cnt_we;
  logic [lgs_pkg::DOC_ADDR_W-1:0]  doc_wa;
  logic [lgs_pkg::WORD_ADDR_W-1:0] word_wa;
  logic [TW-1:0]                   tot_wa;
  logic [lgs_pkg::DCNT_W-1:0] doc_wd;
  logic [lgs_pkg::WCNT_W-1:0] word_wd;
  logic [lgs_pkg::TOT_W-1:0]  tot_wd;
  logic                       rw_we;

  // weight unit
  lgs_pkg::lgs_wu_ops_t    wu_ops;
  logic                    wu_start, wu_done;
  logic [lgs_pkg::W_W-1:0] wu_weight;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_topics_r <= K_LIMIT;
      alpha_r      <= 32'd51200;
      beta_r       <= 32'd655;
      beta_bar_r   <= 32'd2684355;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        lgs_pkg::REG_NUM_TOPICS: num_topics_r <= cfg_pwdata[KW-1:0];
        lgs_pkg::REG_ALPHA:      alpha_r      <= cfg_pwdata;
        lgs_pkg::REG_BETA:       beta_r       <= cfg_pwdata;
        lgs_pkg::REG_BETA_BAR:   beta_bar_r   <= cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      lgs_pkg::REG_NUM_TOPICS: cfg_prdata = {{(32-KW){1'b0}}, num_topics_r};
      lgs_pkg::REG_ALPHA:      cfg_prdata = alpha_r;
      lgs_pkg::REG_BETA:       cfg_prdata = beta_r;
      lgs_pkg::REG_BETA_BAR:   cfg_prdata = beta_bar_r;
    endcase
  end

  // topics in use: 0 acts as 1, above the limit clamps
  always_comb begin
    priority if (num_topics_r == '0)    k_w = KW'(1);
    else if (num_topics_r > K_LIMIT)    k_w = K_LIMIT;
    else                                k_w = num_topics_r;
  end

  // ---------------- count memories ----------------
  always_comb begin
    priority if (state_r == ST_RD1) rd_topic = cur_r;
    else if (state_r == ST_RD2)     rd_topic = pick_r;
    else                            rd_topic = t_r;
  end

  assign wr_topic = (state_r == ST_WB1) ? cur_r : pick_r;
  assign up       = (state_r == ST_WB2) || !op_r;
  assign upd_en   = ((state_r == ST_WB1) && ({1'b0, cur_r} < k_w)) || (state_r == ST_WB2);
  assign clearing = (state_r == ST_CLEAR);
  assign cnt_we   = clearing || upd_en;

  // sweep after reset: the doc and totals tables wrap over the low address bits
  assign doc_wa  = clearing ? clr_r[lgs_pkg::DOC_ADDR_W-1:0] : {doc_r, wr_topic};
  assign word_wa = clearing ? clr_r : {word_r, wr_topic};
  assign tot_wa  = clearing ? clr_r[TW-1:0] : wr_topic;

  always_comb begin
    if (clearing) begin
      doc_wd  = '0;
      word_wd = '0;
      tot_wd  = '0;
    end else if (up) begin
      doc_wd  = (doc_rd_r  == DCNT_MAX) ? doc_rd_r  : doc_rd_r  + 1'b1;
      word_wd = (word_rd_r == WCNT_MAX) ? word_rd_r : word_rd_r + 1'b1;
      tot_wd  = (tot_rd_r  == TOT_MAX)  ? tot_rd_r  : tot_rd_r  + 1'b1;
    end else begin
      doc_wd  = (doc_rd_r  == '0) ? doc_rd_r  : doc_rd_r  - 1'b1;
      word_wd = (word_rd_r == '0) ? word_rd_r : word_rd_r - 1'b1;
      tot_wd  = (tot_rd_r  == '0) ? tot_rd_r  : tot_rd_r  - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) doc_mem[doc_wa] <= doc_wd;
    doc_rd_r <= doc_mem[{doc_r, rd_topic}];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) word_mem[word_wa] <= word_wd;
    word_rd_r <= word_mem[{word_r, rd_topic}];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) tot_mem[tot_wa] <= tot_wd;
    tot_rd_r <= tot_mem[rd_topic];
  end

  // running sums of the weights, written before they are read
  assign rw_we = (state_r == ST_WWAIT) && wu_done;
  always_ff @(posedge clk) begin
    if (rw_we) rw_mem[t_r] <= sum_sat;
    rw_rd_r <= rw_mem[t_r];
  end

  // ---------------- weight datapath ----------------
  assign wu_ops.a = {1'b0, alpha_r} + {1'b0, doc_rd_r, 16'h0};
  assign wu_ops.b = {5'b0, beta_r} + {1'b0, word_rd_r, 16'h0};
  assign wu_ops.c = {9'b0, beta_bar_r} + {1'b0, tot_rd_r, 16'h0};
  assign wu_start = (state_r == ST_WDAT);

  lgs_weight_unit u_weight (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wu_start),
    .ops    (wu_ops),
    .done   (wu_done),
    .weight (wu_weight)
  );

  assign sum_add = {1'b0, sum_r} + {1'b0, wu_weight};
  assign sum_sat = sum_add[lgs_pkg::W_W] ? lgs_pkg::WEIGHT_MAX : sum_add[lgs_pkg::W_W-1:0];
  assign last_t  = ({1'b0, t_r} == k_w - 1'b1);

  // target = floor(frac * sum / 2^32), right-shifting shift-add multiply
  assign acc_add = {1'b0, acc_r[79:32]} + (frac_r[0] ? {1'b0, sum_r} : '0);
  assign target  = acc_r[79:32];

  // ---------------- sequencer ----------------
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    pick_nxt       = pick_r;
    tcnt_nxt       = tcnt_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    frac_nxt       = frac_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_topic_nxt  = out_topic_r;
    unique case (state_r)
      ST_CLEAR: if (&clr_r) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          frac_nxt  = in_tdata[59:28];
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: state_nxt = ST_WB1;
      ST_WB1: begin
        t_nxt   = '0;
        sum_nxt = '0;
        if (op_r) begin
          state_nxt = ST_WRD;
        end else begin
          pick_nxt  = cur_r;
          state_nxt = ST_DONE;
        end
      end
      ST_WRD:  state_nxt = ST_WDAT;
      ST_WDAT: state_nxt = ST_WWAIT;
      ST_WWAIT: begin
        if (wu_done) begin
          sum_nxt = sum_sat;
          if (last_t) begin
            acc_nxt   = '0;
            tcnt_nxt  = '0;
            state_nxt = ST_TGT;
          end else begin
            t_nxt     = t_r + 1'b1;
            state_nxt = ST_WRD;
          end
        end
      end
      ST_TGT: begin
        acc_nxt  = {acc_add, acc_r[31:1]};
        frac_nxt = {1'b0, frac_r[lgs_pkg::FRAC_W-1:1]};
        tcnt_nxt = tcnt_r + 1'b1;
        if (&tcnt_r) begin
          t_nxt     = '0;
          state_nxt = ST_SRD;
        end
      end
      ST_SRD: state_nxt = ST_SCMP;
      ST_SCMP: begin
        // first running sum above the target, else the last topic
        if ((rw_rd_r > target) || last_t) begin
          pick_nxt  = t_r;
          state_nxt = ST_RD2;
        end else begin
          t_nxt     = t_r + 1'b1;
          state_nxt = ST_SRD;
        end
      end
      ST_RD2: state_nxt = ST_WB2;
      ST_WB2: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_topic_nxt  = pick_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      tcnt_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clearing ? clr_r + 1'b1 : clr_r;
      out_tvalid_r <= out_tvalid_nxt;
      tcnt_r       <= tcnt_nxt;
    end
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      doc_r  <= in_tdata[9:0];
      word_r <= in_tdata[21:10];
      cur_r  <= in_tdata[27:22];
    end
    frac_r      <= frac_nxt;
    t_r         <= t_nxt;
    pick_r      <= pick_nxt;
    sum_r       <= sum_nxt;
    acc_r       <= acc_nxt;
    out_topic_r <= out_topic_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b0, out_topic_r};

  // ---------------- assertions ----------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input accepted during clearing sweep");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RD1))
    else $error("accepted transfer did not start an item");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB2) |-> ({1'b0, pick_r} < k_w))
    else $error("picked topic outside topics in use");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCMP) |-> ({1'b0, t_r} < k_w))
    else $error("search ran past the last topic");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    wu_done |-> (state_r == ST_WWAIT))
    else $error("weight unit finished outside its wait state");

endmodule
`default_nettype wire

// File: sv/lgs_weight_unit.sv
// Iterative a*b/c weight unit: shift-add multiply, then restoring divide.
`default_nettype none
module lgs_weight_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire lgs_pkg::lgs_wu_ops_t      ops,
  output logic                           done,
  output logic [lgs_pkg::W_W-1:0]        weight
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  localparam logic [lgs_pkg::STEP_W-1:0] MUL_LAST = lgs_pkg::STEP_W'(lgs_pkg::B_W - 1);
  localparam logic [lgs_pkg::STEP_W-1:0] DIV_LAST = lgs_pkg::STEP_W'(lgs_pkg::P_W - 1);

  logic [1:0]                   phase_r, phase_nxt;
  logic [lgs_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [lgs_pkg::P_W-1:0]      mcand_r, mcand_nxt;
  logic [lgs_pkg::B_W-1:0]      mplier_r, mplier_nxt;
  logic [lgs_pkg::P_W-1:0]      prod_r, prod_nxt;
  logic [lgs_pkg::C_W-1:0]      den_r, den_nxt;
  logic [lgs_pkg::C_W-1:0]      rem_r, rem_nxt;
  logic [lgs_pkg::P_W-1:0]      quo_r, quo_nxt;
  logic [lgs_pkg::C_W:0]        trial;
  logic [lgs_pkg::C_W:0]        diff;
  logic                         fits;

  assign trial = {rem_r, prod_r[lgs_pkg::P_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          mcand_nxt  = {{lgs_pkg::B_W{1'b0}}, ops.a};
          mplier_nxt = ops.b;
          den_nxt    = ops.c;
          prod_nxt   = '0;
          cnt_nxt    = '0;
          phase_nxt  = PH_MUL;
        end
      end
      PH_MUL: begin
        if (mplier_r[0]) prod_nxt = prod_r + mcand_r;
        mcand_nxt  = {mcand_r[lgs_pkg::P_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[lgs_pkg::B_W-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          phase_nxt = PH_DIV;
        end
      end
      PH_DIV: begin
        rem_nxt  = fits ? diff[lgs_pkg::C_W-1:0] : trial[lgs_pkg::C_W-1:0];
        quo_nxt  = {quo_r[lgs_pkg::P_W-2:0], fits};
        prod_nxt = {prod_r[lgs_pkg::P_W-2:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
  end

  assign done   = done_r;
  // quotient above 48 bits saturates
  assign weight = (|quo_r[lgs_pkg::P_W-1:lgs_pkg::W_W]) ? lgs_pkg::WEIGHT_MAX
                                                        : quo_r[lgs_pkg::W_W-1:0];

endmodule
`default_nettype wire
